// ----- rtl/cnms_pkg.sv -----
// Shared types and constants for the color nearest-match sorter.
// No dependencies; every other file in rtl/ but cnms_ram imports this package.
package cnms_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_SLOTS    = 16;
  localparam int DEF_CHANNEL_BITS = 16;

  // Lane arrangement: slot k lives in lane k mod NUM_LANES, row k / NUM_LANES
  localparam int LANE_BITS    = 2;
  localparam int NUM_LANES    = 1 << LANE_BITS;
  localparam int NUM_CHANNELS = 4;

  // Fixed widths of the ports and of the lane result record
  localparam int LEVEL_W    = 16;
  localparam int PORT_SLOT_W = 4;
  localparam int COUNT_W    = 16;
  localparam int CFG_W      = 5;
  localparam int SLOT_MAX_W = 8;   // enough for the largest slot table
  localparam int DIST_MAX_W = 16;  // enough for the widest channel

  // Configuration register indexes
  localparam logic REG_OBJECTS_IN_USE = 1'b0;
  localparam logic REG_TARGET_CLASS   = 1'b1;

  // Request op codes
  localparam logic OP_STORE    = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  typedef struct packed {
    logic                   op;
    logic [PORT_SLOT_W-1:0] slot;
    logic [LEVEL_W-1:0]     red_level;
    logic [LEVEL_W-1:0]     green_level;
    logic [LEVEL_W-1:0]     blue_level;
    logic [LEVEL_W-1:0]     clear_level;
  } cnms_req_t;

  typedef struct packed {
    logic [PORT_SLOT_W-1:0] best_slot;
    logic [LEVEL_W-1:0]     best_distance;
    logic                   is_target;
    logic [COUNT_W-1:0]     match_total;
    logic [COUNT_W-1:0]     reading_total;
  } cnms_rsp_t;

  // Best candidate found by one lane, or by the merge
  typedef struct packed {
    logic                  found;
    logic [SLOT_MAX_W-1:0] slot;
    logic [DIST_MAX_W-1:0] distance;
  } cnms_best_t;

  // Scan control from the sequencer to every lane
  typedef struct packed {
    logic clear;  // drop the lane's best before a new reading
    logic rd_en;  // read one row of the lane's table
  } cnms_lane_ctl_t;

endpackage

// ----- rtl/cnms_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used by each lane for its share of the reference table.
module cnms_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/cnms_lane.sv -----
// One scan lane: its part of the reference table, the L1 distance pipe
// and the running best of its slots. Depends on cnms_pkg and cnms_ram.
module cnms_lane
  import cnms_pkg::*;
#(
  parameter int MAX_SLOTS    = DEF_MAX_SLOTS,
  parameter int CHANNEL_BITS = DEF_CHANNEL_BITS,
  parameter int LANE_ID      = 0,
  parameter int ROWS         = (MAX_SLOTS + NUM_LANES - 1) / NUM_LANES,
  parameter int ROW_W        = (ROWS > 1) ? $clog2(ROWS) : 1,
  parameter int SLOT_W       = ROW_W + LANE_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [ROW_W-1:0]                 wr_row,
  input  logic [NUM_CHANNELS*CHANNEL_BITS-1:0] wr_data,
  input  cnms_lane_ctl_t                   ctl,
  input  logic [ROW_W-1:0]                 rd_row,
  input  logic [NUM_CHANNELS*CHANNEL_BITS-1:0] reading,
  input  logic [SLOT_W:0]                  count,
  output cnms_best_t                       best
);

  localparam int SUM_W = CHANNEL_BITS + 2;
  localparam logic [LANE_BITS-1:0] LANE_IDX = LANE_BITS'(LANE_ID);

  logic [NUM_CHANNELS*CHANNEL_BITS-1:0] rd_data;
  logic                    s1_valid;
  logic [ROW_W-1:0]        s1_row;
  logic                    s2_valid;
  logic                    s2_ok;
  logic [SLOT_W-1:0]       s2_slot;
  logic [CHANNEL_BITS-1:0] s2_diff [NUM_CHANNELS];
  logic [CHANNEL_BITS-1:0] diff_next [NUM_CHANNELS];
  logic [SUM_W-1:0]        sum;
  logic [DIST_MAX_W-1:0]   slot_dist;

  cnms_ram #(
    .WIDTH (NUM_CHANNELS * CHANNEL_BITS),
    .DEPTH (ROWS),
    .ADDR_W(ROW_W)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_row),
    .wdata(wr_data),
    .re   (ctl.rd_en),
    .raddr(rd_row),
    .rdata(rd_data)
  );

  // Absolute channel differences against the row just read
  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (reading[c*CHANNEL_BITS +: CHANNEL_BITS] >= rd_data[c*CHANNEL_BITS +: CHANNEL_BITS])
        diff_next[c] = reading[c*CHANNEL_BITS +: CHANNEL_BITS]
                     - rd_data[c*CHANNEL_BITS +: CHANNEL_BITS];
      else
        diff_next[c] = rd_data[c*CHANNEL_BITS +: CHANNEL_BITS]
                     - reading[c*CHANNEL_BITS +: CHANNEL_BITS];
    end
  end

  // Sum of differences, divided by four
  always_comb begin
    sum = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      sum = sum + SUM_W'(s2_diff[c]);
    end
    slot_dist = DIST_MAX_W'(sum[SUM_W-1:2]);
  end

  // Pipe: read -> differences -> compare
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      best.found <= 1'b0;
    end else begin
      s1_valid <= ctl.rd_en;
      s1_row   <= rd_row;
      s2_valid <= s1_valid;
      s2_slot  <= {s1_row, LANE_IDX};
      s2_ok    <= {1'b0, s1_row, LANE_IDX} < count;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        s2_diff[c] <= diff_next[c];
      end
      // Rows come in ascending order, so a tie keeps the earlier slot
      if (ctl.clear) begin
        best.found <= 1'b0;
      end else if (s2_valid && s2_ok && (!best.found || slot_dist < best.distance)) begin
        best.found    <= 1'b1;
        best.slot     <= SLOT_MAX_W'(s2_slot);
        best.distance <= slot_dist;
      end
    end
  end

endmodule

// ----- rtl/cnms_merge.sv -----
// Merge stage: picks the nearest of the lane winners, lower slot on a tie.
// Depends on cnms_pkg.
module cnms_merge
  import cnms_pkg::*;
(
  input  logic       clk,
  input  cnms_best_t lane_best [NUM_LANES],
  output cnms_best_t merged
);

  cnms_best_t pick;

  always_comb begin
    pick = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (lane_best[i].found &&
          (!pick.found || lane_best[i].distance < pick.distance ||
           (lane_best[i].distance == pick.distance && lane_best[i].slot < pick.slot))) begin
        pick = lane_best[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    merged <= pick;
  end

endmodule

// ----- rtl/color_nearest_match_sorter.sv -----
// Color nearest-match sorter: top level with sequencer, counters and output register.
// Depends on cnms_pkg, cnms_lane, cnms_merge (and cnms_ram through the lanes).
//
// A store request writes one reference slot. A classify request scans the
// slots in use in four lanes, one row of four slots per cycle, so it holds the
// block from acceptance to the next request accepted through the row scan,
// the lane pipe (table read, channel differences, sum and compare), the merge
// register and the load of the response register. A finished response
// waits in its own register, so new requests are taken while it is unclaimed;
// a second classify waits at its end only if the first response is still held.
module color_nearest_match_sorter
  import cnms_pkg::*;
#(
  parameter int MAX_SLOTS    = DEF_MAX_SLOTS,
  parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             req_valid,
  output logic             req_ready,
  input  cnms_req_t        req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output cnms_rsp_t        rsp
);

  localparam int ROWS   = (MAX_SLOTS + NUM_LANES - 1) / NUM_LANES;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SLOT_W = ROW_W + LANE_BITS;
  localparam int DATA_W = NUM_CHANNELS * CHANNEL_BITS;
  localparam int DRAIN_CYCLES = 3;
  localparam int HIT_W  = SLOT_MAX_W + 1;

  typedef enum logic [1:0] {IDLE, SCAN, DRAIN, DONE} state_t;

  state_t               state;
  logic [CFG_W-1:0]     objects_in_use;
  logic [CFG_W-1:0]     target_class;
  logic [SLOT_W:0]      count;
  logic [SLOT_W:0]      count_next;
  logic [ROW_W-1:0]     last_row;
  logic [ROW_W-1:0]     last_row_next;
  logic [ROW_W-1:0]     row;
  logic [1:0]           drain;
  logic [DATA_W-1:0]    reading;
  logic [DATA_W-1:0]    req_levels;
  logic [ROW_W-1:0]     wr_row;
  logic [LANE_BITS-1:0] wr_lane;
  logic                 store_fire;
  logic                 classify_fire;
  logic                 rsp_load;
  logic                 hit;
  logic [COUNT_W-1:0]   match_count;
  logic [COUNT_W-1:0]   reading_count;
  cnms_lane_ctl_t       lane_ctl;
  cnms_best_t           lane_best [NUM_LANES];
  cnms_best_t           merged;

  // Handshake decode
  assign req_ready     = (state == IDLE);
  assign store_fire    = req_valid && req_ready && (req.op == OP_STORE)
                         && (int'(req.slot) < MAX_SLOTS);
  assign classify_fire = req_valid && req_ready && (req.op == OP_CLASSIFY);

  // Response register loads when the scan is done and the slot is free
  assign rsp_load = (state == DONE) && (!rsp_valid || rsp_ready);

  // Channel levels, trimmed to the channel width
  assign req_levels = {req.red_level[CHANNEL_BITS-1:0], req.green_level[CHANNEL_BITS-1:0],
                       req.blue_level[CHANNEL_BITS-1:0], req.clear_level[CHANNEL_BITS-1:0]};
  assign wr_lane = req.slot[LANE_BITS-1:0];
  assign wr_row  = ROW_W'(int'(req.slot) >> LANE_BITS);

  // Slots compared: clamp the register to 1..MAX_SLOTS
  always_comb begin
    int cnt;
    cnt = int'(objects_in_use);
    if (cnt < 1) cnt = 1;
    if (cnt > MAX_SLOTS) cnt = MAX_SLOTS;
    count_next    = (SLOT_W + 1)'(cnt);
    last_row_next = ROW_W'((cnt - 1) >> LANE_BITS);
  end

  assign lane_ctl.clear = classify_fire;
  assign lane_ctl.rd_en = (state == SCAN);

  // Scan lanes
  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    cnms_lane #(
      .MAX_SLOTS   (MAX_SLOTS),
      .CHANNEL_BITS(CHANNEL_BITS),
      .LANE_ID     (i)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .wr_en  (store_fire && (wr_lane == LANE_BITS'(i))),
      .wr_row (wr_row),
      .wr_data(req_levels),
      .ctl    (lane_ctl),
      .rd_row (row),
      .reading(reading),
      .count  (count),
      .best   (lane_best[i])
    );
  end

  cnms_merge u_merge (
    .clk      (clk),
    .lane_best(lane_best),
    .merged   (merged)
  );

  assign hit = (HIT_W'(merged.slot) + HIT_W'(1)) == HIT_W'(target_class);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      objects_in_use <= CFG_W'(1);
      target_class   <= CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OBJECTS_IN_USE: objects_in_use <= cfg_data;
        REG_TARGET_CLASS:   target_class   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer, counters and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      rsp_valid     <= 1'b0;
      match_count   <= '0;
      reading_count <= '0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (classify_fire) begin
            reading  <= req_levels;
            count    <= count_next;
            last_row <= last_row_next;
            row      <= '0;
            state    <= SCAN;
          end
        end
        SCAN: begin
          if (row == last_row) begin
            drain <= '0;
            state <= DRAIN;
          end else begin
            row <= row + ROW_W'(1);
          end
        end
        DRAIN: begin
          if (drain == 2'(DRAIN_CYCLES - 1)) begin
            state <= DONE;
          end else begin
            drain <= drain + 2'd1;
          end
        end
        DONE: begin
          if (rsp_load) begin
            rsp.best_slot     <= merged.slot[PORT_SLOT_W-1:0];
            rsp.best_distance <= LEVEL_W'(merged.distance);
            rsp.is_target     <= hit;
            rsp.reading_total <= reading_count + COUNT_W'(1);
            rsp.match_total   <= hit ? match_count + COUNT_W'(1) : match_count;
            reading_count     <= reading_count + COUNT_W'(1);
            if (hit) begin
              match_count <= match_count + COUNT_W'(1);
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
